FILE: rtl/core/dnbr_pkg.sv
`timescale 1ns / 1ps

package dnbr_pkg;

  localparam int CNT_W     = 24;
  localparam int NIB_W     = 4;
  localparam int BYTE_W    = 2 * NIB_W;
  localparam int IN_DATA_W = 8;   // nibble + strobe, padded to a byte
  localparam int CFG_IDX_W = 2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [NIB_W-1:0] nib_t;

  localparam cnt_t CNT_MAX      = {CNT_W{1'b1}};
  localparam cnt_t STABLE_RESET = cnt_t'(20 * 1000);
  localparam cnt_t WAIT_RESET   = cnt_t'(1000000);

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TIMEOUT    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    phase_t phase;
    cnt_t   wait_count;
    cnt_t   run_count;
    nib_t   held_nibble;
    logic   held_valid;
    nib_t   low_part;
    nib_t   last_part;
    logic   last_valid;
  } state_t;

  typedef struct packed {
    logic strobe;
    nib_t nibble;
  } sample_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] byte_value;
    status_t           status;
  } result_t;

  typedef struct packed {
    cnt_t stable_ticks;
    cnt_t wait_ticks;
  } cfg_t;

endpackage

FILE: rtl/core/dnbr_in_reg.sv
`timescale 1ns / 1ps

module dnbr_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dnbr_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          advance,
  output logic                          smp_valid,
  output dnbr_pkg::sample_t             smp
);
  import dnbr_pkg::*;

  logic    valid_r;
  sample_t smp_r;

  // Take a new word whenever the held one is empty or moves on this cycle
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_r.nibble <= in_tdata[NIB_W-1:0];
      smp_r.strobe <= in_tdata[NIB_W];
    end
  end

  assign smp_valid = valid_r;
  assign smp       = smp_r;

endmodule

FILE: rtl/core/dnbr_step.sv
`timescale 1ns / 1ps

module dnbr_step (
  input  dnbr_pkg::state_t  cur,
  input  dnbr_pkg::sample_t smp,
  input  dnbr_pkg::cfg_t    cfg,
  output dnbr_pkg::state_t  nxt,
  output dnbr_pkg::result_t res
);
  import dnbr_pkg::*;

  logic hv;
  nib_t hn;
  cnt_t rc;
  cnt_t rc_trk;
  cnt_t wc_inc;
  logic stable;

  // Tracker as seen by this sample: cleared when the word starts here
  always_comb begin
    hv = cur.held_valid;
    hn = cur.held_nibble;
    rc = cur.run_count;
    if (cur.phase != PH_LOW && cur.phase != PH_HIGH) begin
      hv = 1'b0;
      hn = '0;
      rc = '0;
    end
    if (!hv || smp.nibble != hn) begin
      rc_trk = cnt_t'(1);
    end else if (rc != CNT_MAX) begin
      rc_trk = rc + cnt_t'(1);
    end else begin
      rc_trk = rc;
    end
    stable = (rc_trk >= cfg.stable_ticks);
    wc_inc = (cur.wait_count != CNT_MAX) ? cur.wait_count + cnt_t'(1) : cur.wait_count;
  end

  always_comb begin
    nxt = cur;
    res = '{valid: 1'b0, byte_value: '0, status: ST_OK};
    unique case (cur.phase)
      PH_LOW: begin
        if (!smp.strobe) begin
          nxt.phase       = PH_WAIT;
          nxt.wait_count  = '0;
          nxt.held_valid  = 1'b0;
          nxt.held_nibble = '0;
          nxt.run_count   = '0;
          nxt.last_valid  = 1'b0;
          res.valid       = 1'b1;
          res.status      = ST_INCOMPLETE;
        end else if (stable) begin
          nxt.low_part    = smp.nibble;
          nxt.phase       = PH_HIGH;
          nxt.held_valid  = 1'b0;
          nxt.held_nibble = '0;
          nxt.run_count   = '0;
          nxt.last_valid  = 1'b0;
        end else begin
          nxt.held_valid  = 1'b1;
          nxt.held_nibble = smp.nibble;
          nxt.run_count   = rc_trk;
        end
      end
      PH_HIGH: begin
        if (!smp.strobe) begin
          nxt.phase       = PH_WAIT;
          nxt.wait_count  = '0;
          nxt.held_valid  = 1'b0;
          nxt.held_nibble = '0;
          nxt.run_count   = '0;
          nxt.last_valid  = 1'b0;
          res.valid       = 1'b1;
          if (cur.last_valid) begin
            res.byte_value = {cur.last_part, cur.low_part};
            res.status     = ST_OK;
          end else begin
            res.status     = ST_INCOMPLETE;
          end
        end else if (stable) begin
          nxt.last_part   = smp.nibble;
          nxt.last_valid  = 1'b1;
          nxt.held_valid  = 1'b0;
          nxt.held_nibble = '0;
          nxt.run_count   = '0;
        end else begin
          nxt.held_valid  = 1'b1;
          nxt.held_nibble = smp.nibble;
          nxt.run_count   = rc_trk;
        end
      end
      default: begin
        // Waiting for the strobe; the unused code behaves the same
        if (!smp.strobe) begin
          if (wc_inc >= cfg.wait_ticks) begin
            nxt.wait_count = '0;
            res.valid      = 1'b1;
            res.status     = ST_TIMEOUT;
          end else begin
            nxt.wait_count = wc_inc;
          end
        end else begin
          nxt.wait_count = '0;
          nxt.last_valid = 1'b0;
          if (stable) begin
            nxt.low_part    = smp.nibble;
            nxt.phase       = PH_HIGH;
            nxt.held_valid  = 1'b0;
            nxt.held_nibble = '0;
            nxt.run_count   = '0;
          end else begin
            nxt.phase       = PH_LOW;
            nxt.held_valid  = 1'b1;
            nxt.held_nibble = smp.nibble;
            nxt.run_count   = rc_trk;
          end
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/dnbr_out_reg.sv
`timescale 1ns / 1ps

module dnbr_out_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  dnbr_pkg::result_t            res,
  output logic                         advance,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dnbr_pkg::BYTE_W-1:0]  out_tdata,
  output logic [1:0]                   out_tuser
);
  import dnbr_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  status_t           status_r;

  // The slot frees up when empty or when the current word is taken
  assign advance = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load && res.valid) begin
      byte_r   <= res.byte_value;
      status_r <= res.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = status_r;

endmodule

FILE: rtl/core/debounced_nibble_bus_receiver.sv
`timescale 1ns / 1ps

// Debounced nibble-bus byte receiver.
// Input channel (in_*): one word per sampled tick of the bus, carrying the four
//   data lines and the transmit strobe. Output channel (out_*): one word per
//   received byte, per incomplete/unstable word, or per strobe wait timeout;
//   out_tuser gives the status and out_tdata the byte (zero unless status ok).
// Configuration (cfg_*): index 0 stable_ticks, index 1 wait_ticks, 24 bits
//   each; cfg_ready is always high. Write only while the block is idle.
// Path: an accepted word waits in the input register; its result (if any) then
//   lands in the result register and drives out_tvalid. Throughput: one word per
//   cycle while out_tready does not hold the result register, limited by the
//   single pass through the step logic between those two registers.
// Reset (rst_n low, synchronous): back to waiting for the strobe, all counters
//   and captured nibbles cleared, both pipeline registers empty, registers to
//   stable_ticks = 20000 and wait_ticks = 1000000.
// Stall: while out_tvalid is high and out_tready low, the result register
//   holds, the step logic does not advance, and in_tready drops once the
//   input register is also full. No word is lost or repeated.
module debounced_nibble_bus_receiver (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dnbr_pkg::IN_DATA_W-1:0]   in_tdata,   // [3:0] nibble_lines, [4] strobe_req
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dnbr_pkg::BYTE_W-1:0]      out_tdata,  // [7:0] byte_value
  output logic [1:0]                       out_tuser,  // [1:0] status
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dnbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dnbr_pkg::CNT_W-1:0]       cfg_data
);
  import dnbr_pkg::*;

  logic    smp_valid;
  sample_t smp;
  logic    advance;
  logic    fire;
  state_t  state_r;
  state_t  state_nxt;
  result_t res;
  cfg_t    cfg_r;
  cfg_t    cfg_nxt;

  // Configuration registers: always ready, unknown indexes drop
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STABLE_TICKS: cfg_nxt.stable_ticks = cfg_data;
        CFG_WAIT_TICKS:   cfg_nxt.wait_ticks   = cfg_data;
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_ticks <= STABLE_RESET;
      cfg_r.wait_ticks   <= WAIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register
  dnbr_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  // One tick of the receive sequence
  dnbr_step u_step (
    .cur (state_r),
    .smp (smp),
    .cfg (cfg_r),
    .nxt (state_nxt),
    .res (res)
  );

  // Advance the state only when the held sample moves into the result slot
  assign fire = smp_valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_WAIT, wait_count: '0, run_count: '0,
                   held_nibble: '0, held_valid: 1'b0, low_part: '0,
                   last_part: '0, last_valid: 1'b0};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  dnbr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Waiting means no tracker and no captured high nibble
  a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_WAIT |-> !state_r.held_valid && !state_r.last_valid &&
                                 state_r.run_count == '0)
    else $error("tracker not clear while waiting");

  // No high nibble may be captured before the low nibble is done
  a_low_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_LOW |-> !state_r.last_valid)
    else $error("high nibble captured during low phase");

  // A good byte only comes out of the high phase with a captured nibble
  a_ok_from_high: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid && res.status == ST_OK |->
      state_r.phase == PH_HIGH && state_r.last_valid)
    else $error("ok result outside a completed word");

  // Error and timeout results carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero byte on error result");

endmodule
